// ===== src/sorted_key_table_defines.svh =====
// assertion macros shared by the sorted key table modules
`ifndef SORTED_KEY_TABLE_DEFINES_SVH
`define SORTED_KEY_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
// checked on every clock edge outside reset
`define SKT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every clock edge, reset included
`define SKT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SKT_ASSERT(label, prop, msg)
`define SKT_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== src/skt_pkg.sv =====
// constants, codes and types of the sorted key table
package skt_pkg;

    // table geometry
    localparam int DEPTH    = 256;
    localparam int KEY_BITS = 32;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);

    // port field widths
    localparam int KIND_W   = 2;
    localparam int KEY_W    = 32;
    localparam int POS_W    = 8;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 8;
    localparam int COUNT_W  = 9;

    // operation codes
    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_BFIND  = 2'd1,
        KIND_GET    = 2'd2,
        KIND_LFIND  = 2'd3
    } kind_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK   = 2'd0,
        STAT_MISS = 2'd1,
        STAT_FULL = 2'd2
    } status_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROBE,
        ST_CMP,
        ST_SHIFT,
        ST_GET,
        ST_SCAN
    } state_t;

    // key store access from the sequencer
    typedef struct packed {
        logic                we;
        logic [ADDR_W-1:0]   waddr;
        logic [KEY_BITS-1:0] wdata;
        logic [ADDR_W-1:0]   raddr;
    } mem_req_t;

    // one result transaction
    typedef struct packed {
        logic               done;
        status_t            status;
        logic [INDEX_W-1:0] index;
        logic [KEY_W-1:0]   key_out;
        logic [COUNT_W-1:0] entry_count;
    } result_t;

endpackage

// ===== src/skt_ram.sv =====
// generic single write port ram with registered read
module skt_ram #(
    parameter int DATA_W     = 32,
    parameter int ADDR_DEPTH = 256
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic [$clog2(ADDR_DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]             wdata,
    input  logic [$clog2(ADDR_DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]             rdata
);

    logic [DATA_W-1:0] mem [ADDR_DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== src/skt_seq.sv =====
// sequencer of the sorted key table: search, shift and scan around one comparator
`include "sorted_key_table_defines.svh"

module skt_seq
    import skt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [KIND_W-1:0]   kind,
    input  logic [KEY_W-1:0]    key,
    input  logic [POS_W-1:0]    position,
    input  logic                sorted_mode,
    input  logic [KEY_BITS-1:0] rd_data,
    output mem_req_t            mem_req,
    output result_t             result,
    output logic                busy
);

    state_t              state_reg, state_next;
    kind_t               op_reg, op_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [CNT_W-1:0]    left_reg, left_next;
    logic [CNT_W-1:0]    hi_reg, hi_next;
    logic [CNT_W-1:0]    ptr_reg, ptr_next;
    logic [CNT_W-1:0]    rem_reg, rem_next;
    logic                pend_reg, pend_next;
    logic [ADDR_W-1:0]   pend_addr_reg, pend_addr_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    result_t             res_reg, res_next;

    kind_t            kind_in;
    logic             key_eq;
    logic             key_gt;
    logic [CNT_W-1:0] mid;
    logic             range_open;
    logic             table_full;
    logic             direct_ins;
    logic             get_ok;
    logic             scan_issue;
    logic             scan_hit;

    assign kind_in = kind_t'(kind);

    // shared comparator on the key store read data
    assign key_eq = (rd_data == key_reg);
    assign key_gt = (rd_data > key_reg);

    // binary search window [left, hi)
    assign range_open = (left_reg < hi_reg);
    assign mid        = left_reg + ((hi_reg - left_reg - 1'b1) >> 1);

    // decisions at the start of a transaction
    assign table_full = (count_reg == CNT_W'(DEPTH));
    assign direct_ins = !sorted_mode || (count_reg == '0);
    assign get_ok     = (32'(position) < 32'(count_reg));

    // linear scan pipeline
    assign scan_issue = (ptr_reg < count_reg);
    assign scan_hit   = pend_reg && key_eq;

    assign busy   = (state_reg != ST_IDLE);
    assign result = res_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (kind_in)
                        KIND_INSERT:
                        begin
                            if (table_full)
                                state_next = ST_IDLE;
                            else if (direct_ins)
                                state_next = ST_SHIFT;
                            else
                                state_next = ST_PROBE;
                        end
                        KIND_BFIND:
                            state_next = direct_ins ? ST_IDLE : ST_PROBE;
                        KIND_GET:
                            state_next = get_ok ? ST_GET : ST_IDLE;
                        KIND_LFIND:
                            state_next = ST_SCAN;
                        default:
                            state_next = ST_IDLE;
                    endcase
                end
            end
            ST_PROBE:
            begin
                if (range_open)
                    state_next = ST_CMP;
                else
                    state_next = (op_reg == KIND_INSERT) ? ST_SHIFT : ST_IDLE;
            end
            ST_CMP:
            begin
                if (key_eq)
                    state_next = (op_reg == KIND_INSERT) ? ST_SHIFT : ST_IDLE;
                else
                    state_next = ST_PROBE;
            end
            ST_SHIFT:
            begin
                if ((rem_reg == '0) && !pend_reg)
                    state_next = ST_IDLE;
            end
            ST_GET:
                state_next = ST_IDLE;
            ST_SCAN:
            begin
                if (scan_hit || (!scan_issue && !pend_reg))
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath, memory access and result
    always_comb
    begin
        op_next        = op_reg;
        key_next       = key_reg;
        pos_next       = pos_reg;
        left_next      = left_reg;
        hi_next        = hi_reg;
        ptr_next       = ptr_reg;
        rem_next       = rem_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        count_next     = count_reg;
        res_next       = res_reg;
        res_next.done  = 1'b0;
        mem_req.we     = 1'b0;
        mem_req.waddr  = pend_addr_reg + 1'b1;
        mem_req.wdata  = rd_data;
        mem_req.raddr  = ADDR_W'(ptr_reg);

        unique case (state_reg)
            ST_IDLE:
            begin
                mem_req.raddr = ADDR_W'(position);
                if (start)
                begin
                    op_next   = kind_in;
                    key_next  = KEY_BITS'(key);
                    pos_next  = position;
                    left_next = '0;
                    hi_next   = count_reg;
                    ptr_next  = '0;
                    pend_next = 1'b0;
                    // miss unless an arm below says otherwise
                    res_next.index       = '0;
                    res_next.key_out     = '0;
                    res_next.entry_count = COUNT_W'(count_reg);
                    res_next.status      = STAT_MISS;
                    unique case (kind_in)
                        KIND_INSERT:
                        begin
                            if (table_full)
                            begin
                                res_next.status = STAT_FULL;
                                res_next.done   = 1'b1;
                            end
                            else if (direct_ins)
                            begin
                                // append at the end: nothing to move
                                left_next = count_reg;
                                rem_next  = '0;
                            end
                        end
                        KIND_BFIND:
                            res_next.done = direct_ins;
                        KIND_GET:
                            res_next.done = !get_ok;
                        KIND_LFIND:
                            res_next.done = 1'b0;
                        default:
                            res_next.done = 1'b0;
                    endcase
                end
            end
            ST_PROBE:
            begin
                mem_req.raddr = ADDR_W'(mid);
                if (!range_open)
                begin
                    if (op_reg == KIND_INSERT)
                    begin
                        // insert at left, move entries left..count-1 up
                        rem_next  = count_reg - left_reg;
                        ptr_next  = count_reg - 1'b1;
                        pend_next = 1'b0;
                    end
                    else
                    begin
                        res_next.done = 1'b1;
                    end
                end
            end
            ST_CMP:
            begin
                if (key_eq)
                begin
                    if (op_reg == KIND_INSERT)
                    begin
                        left_next = mid;
                        rem_next  = count_reg - mid;
                        ptr_next  = count_reg - 1'b1;
                        pend_next = 1'b0;
                    end
                    else
                    begin
                        res_next.done    = 1'b1;
                        res_next.status  = STAT_OK;
                        res_next.index   = INDEX_W'(mid);
                        res_next.key_out = KEY_W'(rd_data);
                    end
                end
                else if (key_gt)
                begin
                    left_next = mid + 1'b1;
                end
                else
                begin
                    hi_next = mid;
                end
            end
            ST_SHIFT:
            begin
                // write back the entry read last cycle one place up
                mem_req.we = pend_reg;
                if (rem_reg != '0)
                begin
                    pend_next      = 1'b1;
                    pend_addr_next = ADDR_W'(ptr_reg);
                    ptr_next       = ptr_reg - 1'b1;
                    rem_next       = rem_reg - 1'b1;
                end
                else if (pend_reg)
                begin
                    pend_next = 1'b0;
                end
                else
                begin
                    mem_req.we           = 1'b1;
                    mem_req.waddr        = ADDR_W'(left_reg);
                    mem_req.wdata        = key_reg;
                    count_next           = count_reg + 1'b1;
                    res_next.done        = 1'b1;
                    res_next.status      = STAT_OK;
                    res_next.index       = INDEX_W'(left_reg);
                    res_next.key_out     = KEY_W'(key_reg);
                    res_next.entry_count = COUNT_W'(count_reg + 1'b1);
                end
            end
            ST_GET:
            begin
                res_next.done    = 1'b1;
                res_next.status  = STAT_OK;
                res_next.index   = INDEX_W'(pos_reg);
                res_next.key_out = KEY_W'(rd_data);
            end
            ST_SCAN:
            begin
                if (scan_hit)
                begin
                    res_next.done    = 1'b1;
                    res_next.status  = STAT_OK;
                    res_next.index   = INDEX_W'(pend_addr_reg);
                    res_next.key_out = KEY_W'(rd_data);
                end
                else if (!scan_issue && !pend_reg)
                begin
                    res_next.done = 1'b1;
                end
                else
                begin
                    pend_next      = scan_issue;
                    pend_addr_next = ADDR_W'(ptr_reg);
                    if (scan_issue)
                        ptr_next = ptr_reg + 1'b1;
                end
            end
            default:
            begin
                res_next.done = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= KIND_INSERT;
            left_reg  <= '0;
            hi_reg    <= '0;
            ptr_reg   <= '0;
            rem_reg   <= '0;
            pend_reg  <= 1'b0;
            count_reg <= '0;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            left_reg  <= left_next;
            hi_reg    <= hi_next;
            ptr_reg   <= ptr_next;
            rem_reg   <= rem_next;
            pend_reg  <= pend_next;
            count_reg <= count_next;
            res_reg   <= res_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        pos_reg       <= pos_next;
        pend_addr_reg <= pend_addr_next;
    end

    // checks
    `SKT_ASSERT(a_done_when_idle, res_reg.done |-> state_reg == ST_IDLE, "result while busy")
    `SKT_ASSERT(a_count_bound, count_reg <= CNT_W'(DEPTH), "fill count beyond depth")
    `SKT_ASSERT(a_insert_counts, res_reg.done && res_reg.status == STAT_OK && op_reg == KIND_INSERT |-> count_reg == $past(count_reg) + 1'b1, "insert did not add one entry")
    `SKT_ASSERT(a_write_in_range, mem_req.we |-> 32'(mem_req.waddr) <= 32'(count_reg), "write beyond filled part")

endmodule

// ===== src/sorted_key_table.sv =====
// sorted key table top level: mode register, sequencer and key store
//
// channel   direction  handshake            fields
// command   in         start & !busy        kind, key, position
// result    out        done (one cycle)     status, index, key_out, entry_count
// config    in         cfg_write            cfg_data (sorted_mode)
//
// get misses, full inserts and binary finds in unsorted mode or on an empty table answer from
// idle and never raise busy; otherwise busy stays high until the cycle in which done rises
// get: one key store read; binary find: probe and compare until a hit or the window is empty
// insert: search for the slot (the end when unsorted or empty), move the entries from the slot
// up one place, then write the key; linear find: read from entry 0 to a hit or the fill count
// reset empties the table and selects sorted mode; results cannot be stalled
`include "sorted_key_table_defines.svh"

module sorted_key_table
    import skt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [KIND_W-1:0]   kind,
    input  logic [KEY_W-1:0]    key,
    input  logic [POS_W-1:0]    position,
    input  logic                cfg_write,
    input  logic                cfg_data,
    output logic                done,
    output logic [STATUS_W-1:0] status,
    output logic [INDEX_W-1:0]  index,
    output logic [KEY_W-1:0]    key_out,
    output logic [COUNT_W-1:0]  entry_count
);

    logic                sorted_mode_reg;
    mem_req_t            mem_req;
    logic [KEY_BITS-1:0] rd_data;
    result_t             result;

    // mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sorted_mode_reg <= 1'b1;
        else if (cfg_write)
            sorted_mode_reg <= cfg_data;
    end

    // sequencer
    skt_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .kind        (kind),
        .key         (key),
        .position    (position),
        .sorted_mode (sorted_mode_reg),
        .rd_data     (rd_data),
        .mem_req     (mem_req),
        .result      (result),
        .busy        (busy)
    );

    // key store
    skt_ram #(
        .DATA_W     (KEY_BITS),
        .ADDR_DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .raddr (mem_req.raddr),
        .rdata (rd_data)
    );

    // result transaction
    assign done        = result.done;
    assign status      = result.status;
    assign index       = result.index;
    assign key_out     = result.key_out;
    assign entry_count = result.entry_count;

    // checks
    `SKT_ASSERT_ALWAYS(a_quiet_after_reset, !rst_n |=> !done, "result straight after reset")

endmodule

// ===== tb/tb_sorted_key_table.sv =====
`timescale 1ns / 100ps
// self-checking testbench of the sorted key table: directed and random operations
module tb_sorted_key_table;
    import skt_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS   = 10;

    // one result transaction as the checker sees it
    typedef struct packed {
        status_t            status;
        logic [INDEX_W-1:0] index;
        logic [KEY_W-1:0]   key_out;
        logic [COUNT_W-1:0] entry_count;
    } table_reply_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                start     = 1'b0;
    logic                busy;
    logic [KIND_W-1:0]   kind      = '0;
    logic [KEY_W-1:0]    key       = '0;
    logic [POS_W-1:0]    position  = '0;
    logic                cfg_write = 1'b0;
    logic                cfg_data  = 1'b0;
    logic                done;
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  index;
    logic [KEY_W-1:0]    key_out;
    logic [COUNT_W-1:0]  entry_count;

    // shadow copy of the table contents and mode
    logic [KEY_W-1:0] model_keys [DEPTH];
    int               model_fill   = 0;
    bit               model_sorted = 1'b1;

    // replies still owed by the block, oldest first
    table_reply_t pending_replies [$];

    int mismatch_count = 0;
    int stall_cycles   = 0;
    int kind_tally [4] = '{0, 0, 0, 0};
    int full_refusals  = 0;
    int lookup_hits    = 0;
    int mode_writes    = 0;
    bit hold_gaps      = 1'b0;

    table_reply_t seen_reply;
    table_reply_t want_reply;

    sorted_key_table u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .kind        (kind),
        .key         (key),
        .position    (position),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .done        (done),
        .status      (status),
        .index       (index),
        .key_out     (key_out),
        .entry_count (entry_count)
    );

    // clock
    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // binary search over the shadow table, greatest key first
    function automatic int locate_key(logic [KEY_W-1:0] k, output bit hit);
        int left;
        int right;
        int mid;
        hit = 1'b0;
        if (model_fill == 0)
            return 0;
        if (!model_sorted)
            return model_fill;
        left  = 0;
        right = model_fill - 1;
        while (left <= right)
        begin
            mid = left + (right - left) / 2;
            if (model_keys[mid] == k)
            begin
                hit = 1'b1;
                return mid;
            end
            if (left == right)
                return (model_keys[mid] > k) ? mid + 1 : mid;
            if (model_keys[mid] > k)
                left = mid + 1;
            else
                right = mid - 1;
        end
        return left;
    endfunction

    // apply one operation to the shadow table and work out its reply
    function automatic table_reply_t predict_table_op(kind_t op, logic [KEY_W-1:0] k,
                                                      logic [POS_W-1:0] pos);
        table_reply_t r;
        bit           hit;
        int           slot;
        int           i;
        r.status  = STAT_MISS;
        r.index   = '0;
        r.key_out = '0;
        case (op)
            KIND_INSERT:
            begin
                if (model_fill >= DEPTH)
                    r.status = STAT_FULL;
                else
                begin
                    slot = locate_key(k, hit);
                    if (slot > model_fill)
                        slot = model_fill;
                    for (i = model_fill; i > slot; i--)
                        model_keys[i] = model_keys[i-1];
                    model_keys[slot] = k;
                    model_fill++;
                    r.status  = STAT_OK;
                    r.index   = slot[INDEX_W-1:0];
                    r.key_out = k;
                end
            end
            KIND_BFIND:
            begin
                if (model_fill != 0)
                begin
                    slot = locate_key(k, hit);
                    if (hit && slot >= 0 && slot < model_fill)
                    begin
                        r.status  = STAT_OK;
                        r.index   = slot[INDEX_W-1:0];
                        r.key_out = model_keys[slot];
                    end
                end
            end
            KIND_GET:
            begin
                if (int'(pos) < model_fill)
                begin
                    r.status  = STAT_OK;
                    r.index   = pos;
                    r.key_out = model_keys[pos];
                end
            end
            default:
            begin
                for (i = 0; i < model_fill; i++)
                begin
                    if (model_keys[i] == k)
                    begin
                        r.status  = STAT_OK;
                        r.index   = i[INDEX_W-1:0];
                        r.key_out = model_keys[i];
                        break;
                    end
                end
            end
        endcase
        r.entry_count = model_fill[COUNT_W-1:0];
        return r;
    endfunction

    // present one command, hold it until taken, record the reply it owes
    task automatic issue_op(kind_t op, logic [KEY_W-1:0] k, logic [POS_W-1:0] pos);
        int           gap;
        table_reply_t r;
        gap = hold_gaps ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        kind     <= op;
        key      <= k;
        position <= pos;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        r = predict_table_op(op, k, pos);
        pending_replies.push_back(r);
        kind_tally[op]++;
        if (r.status == STAT_FULL)
            full_refusals++;
        if (op != KIND_INSERT && r.status == STAT_OK)
            lookup_hits++;
    endtask

    // stop issuing and wait until every reply is in and the block is idle
    task automatic drain_table();
        start <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // mode register write, only with the block idle
    task automatic set_sort_mode(bit sorted);
        drain_table();
        cfg_write <= 1'b1;
        cfg_data  <= sorted;
        @(posedge clk);
        cfg_write    <= 1'b0;
        model_sorted = sorted;
        mode_writes++;
    endtask

    // keys biased towards extremes, stored keys, their neighbours and small values
    function automatic logic [KEY_W-1:0] pick_key();
        int sel;
        int slot;
        sel = $urandom_range(0, 9);
        if (model_fill == 0 && sel >= 1 && sel <= 4)
            sel = 9;
        slot = (model_fill == 0) ? 0 : $urandom_range(0, model_fill - 1);
        case (sel)
            0:       return $urandom_range(0, 1) ? '1 : '0;
            1, 2, 3: return model_keys[slot];
            4:       return $urandom_range(0, 1) ? model_keys[slot] + 1 : model_keys[slot] - 1;
            5:       return KEY_W'($urandom_range(0, 15));
            default: return $urandom;
        endcase
    endfunction

    // random mix of operations; insert_weight is the insert share in percent
    task automatic run_random_ops(int items, int insert_weight, bit until_full);
        int            n;
        kind_t         op;
        logic [POS_W-1:0] pos;
        n = 0;
        while (until_full ? (model_fill < DEPTH) : (n < items))
        begin
            if ($urandom_range(0, 19) == 0)
                hold_gaps = ~hold_gaps;
            if ($urandom_range(0, 99) < insert_weight)
                op = KIND_INSERT;
            else
                op = kind_t'($urandom_range(1, 3));
            if ($urandom_range(0, 9) < 7)
                pos = (model_fill > 255) ? POS_W'($urandom_range(0, 255))
                                         : POS_W'($urandom_range(0, model_fill));
            else
                pos = POS_W'($urandom_range(0, 255));
            issue_op(op, pick_key(), pos);
            n++;
        end
        hold_gaps = 1'b0;
    endtask

    // lookups on an empty table all miss
    task automatic test_empty_table();
        issue_op(KIND_BFIND, 32'h0000_1234, '0);
        issue_op(KIND_LFIND, 32'h0000_0000, '0);
        issue_op(KIND_GET, 32'h0000_0000, 8'd0);
    endtask

    // inserts in sorted mode with extremes and a duplicate, then lookups
    task automatic test_sorted_order();
        issue_op(KIND_INSERT, 32'h0000_0000, '0);
        issue_op(KIND_INSERT, 32'hFFFF_FFFF, '0);
        issue_op(KIND_INSERT, 32'h8000_0000, '0);
        issue_op(KIND_INSERT, 32'h8000_0000, '0);
        issue_op(KIND_INSERT, 32'h0000_0001, '0);
        issue_op(KIND_BFIND, 32'h8000_0000, '0);
        issue_op(KIND_BFIND, 32'h0000_0005, '0);
        issue_op(KIND_LFIND, 32'h0000_0000, '0);
        issue_op(KIND_GET, 32'h0000_0000, 8'd0);
        issue_op(KIND_GET, 32'h0000_0000, 8'd4);
        issue_op(KIND_GET, 32'h0000_0000, 8'd255);
    endtask

    // append mode, then sorted inserts and finds on the disordered table
    task automatic test_append_mode();
        set_sort_mode(1'b0);
        issue_op(KIND_INSERT, 32'h0000_0007, '0);
        issue_op(KIND_INSERT, 32'hFFFF_FFFF, '0);
        issue_op(KIND_BFIND, 32'h0000_0007, '0);
        issue_op(KIND_LFIND, 32'h0000_0007, '0);
        set_sort_mode(1'b1);
        issue_op(KIND_INSERT, 32'h0000_0003, '0);
        issue_op(KIND_BFIND, 32'h0000_0003, '0);
    endtask

    // random traffic in sorted mode, on the table that the append test left out of order
    task automatic test_random_sorted();
        run_random_ops(330, 45, 1'b0);
    endtask

    // random traffic while appending
    task automatic test_random_append();
        set_sort_mode(1'b0);
        run_random_ops(150, 33, 1'b0);
    endtask

    // back to sorted mode, fill the table, then hammer it while full
    task automatic test_fill_to_capacity();
        set_sort_mode(1'b1);
        run_random_ops(0, 50, 1'b1);
        run_random_ops(60, 40, 1'b0);
    endtask

    // compare every result against the oldest outstanding reply
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            seen_reply = '{status_t'(status), index, key_out, entry_count};
            if (pending_replies.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: unexpected result status %0d index %0d key %h count %0d",
                             $time, status, index, key_out, entry_count);
            end
            else
            begin
                want_reply = pending_replies.pop_front();
                if (seen_reply.status !== want_reply.status ||
                    seen_reply.index !== want_reply.index ||
                    seen_reply.key_out !== want_reply.key_out ||
                    seen_reply.entry_count !== want_reply.entry_count)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: mismatch exp st %0d idx %0d key %h cnt %0d, got st %0d idx %0d key %h cnt %0d",
                                 $time, want_reply.status, want_reply.index,
                                 want_reply.key_out, want_reply.entry_count,
                                 seen_reply.status, seen_reply.index,
                                 seen_reply.key_out, seen_reply.entry_count);
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    // test sequence
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_table();
        test_sorted_order();
        test_append_mode();
        test_random_sorted();
        test_random_append();
        test_fill_to_capacity();
        drain_table();
        $display("ran %0d inserts (%0d refused when full), %0d binary finds, %0d gets, %0d linear finds",
                 kind_tally[KIND_INSERT], full_refusals, kind_tally[KIND_BFIND],
                 kind_tally[KIND_GET], kind_tally[KIND_LFIND]);
        $display("%0d lookups hit, %0d mode writes, final fill %0d, %0d mismatches",
                 lookup_hits, mode_writes, model_fill, mismatch_count);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
